/* rtl/nshr_pkg.sv */
// Shared types and codes for the nearest segment hit block.
// No dependencies.
`default_nettype none
package nshr_pkg;
  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } unit_ctl_t;
endpackage
`default_nettype wire

/* rtl/nshr_if.sv */
// Valid/ready channel interfaces for edge items and result items.
// No dependencies.
`default_nettype none
interface nshr_in_if #(parameter int CB = 16, parameter int TB = 8);
  logic valid;
  logic ready;
  logic first;
  logic last;
  logic signed [CB-1:0] ray_start_x;
  logic signed [CB-1:0] ray_start_y;
  logic signed [CB-1:0] ray_end_x;
  logic signed [CB-1:0] ray_end_y;
  logic signed [CB-1:0] edge_a_x;
  logic signed [CB-1:0] edge_a_y;
  logic signed [CB-1:0] edge_b_x;
  logic signed [CB-1:0] edge_b_y;
  logic [TB-1:0] part_tag;
  logic is_robot;
  modport source(output valid, first, last, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
                 edge_a_x, edge_a_y, edge_b_x, edge_b_y, part_tag, is_robot, input ready);
  modport sink(input valid, first, last, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
               edge_a_x, edge_a_y, edge_b_x, edge_b_y, part_tag, is_robot, output ready);
endinterface

interface nshr_out_if #(parameter int CB = 16, parameter int TB = 8);
  logic valid;
  logic ready;
  logic hit;
  logic [CB:0] distance;
  logic signed [CB-1:0] hit_x;
  logic signed [CB-1:0] hit_y;
  logic [TB-1:0] hit_tag;
  modport source(output valid, hit, distance, hit_x, hit_y, hit_tag, input ready);
  modport sink(input valid, hit, distance, hit_x, hit_y, hit_tag, output ready);
endinterface
`default_nettype wire

/* rtl/nshr_unit.sv */
// Shared restoring divide / square root unit, one result bit per cycle.
// Depends on nshr_pkg.
`default_nettype none
module nshr_unit #(
  parameter int NW  = 52,
  parameter int DVW = 35
) (
  input  logic                clk,
  input  logic                rst,
  input  nshr_pkg::unit_ctl_t ctl,
  input  logic [NW-1:0]       operand,
  input  logic [DVW-1:0]      divisor,
  output logic                busy,
  output logic                done,
  output logic [NW-1:0]       result,
  output logic                rem_nz
);
  localparam int RW = (DVW + 1 > NW / 2 + 3) ? DVW + 1 : NW / 2 + 3;
  localparam int CW = $clog2(NW + 1);

  logic          mode;
  logic [CW-1:0] cnt;
  logic [NW-1:0] opnd;
  logic [NW-1:0] res;
  logic [RW-1:0] rem;
  logic [DVW-1:0] dv;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    if (mode == nshr_pkg::MODE_DIV) begin
      rem_sh = {rem[RW-2:0], opnd[NW-1]};
      trial  = RW'(dv);
    end else begin
      rem_sh = {rem[RW-3:0], opnd[NW-1:NW-2]};
      trial  = {res[RW-3:0], 2'b01};
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && (cnt == CW'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        mode <= ctl.mode;
        opnd <= operand;
        dv   <= divisor;
        res  <= '0;
        rem  <= '0;
        cnt  <= (ctl.mode == nshr_pkg::MODE_DIV) ? CW'(NW) : CW'(NW / 2);
      end else if (busy) begin
        rem <= ge ? rem_sh - trial : rem_sh;
        res <= {res[NW-2:0], ge};
        opnd <= (mode == nshr_pkg::MODE_DIV) ? {opnd[NW-2:0], 1'b0} : {opnd[NW-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = res;
  assign rem_nz = rem != '0;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("unit not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("unit done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !ctl.start)
    else $error("unit restarted while busy");
`endif
endmodule
`default_nettype wire

/* rtl/nearest_segment_hit_raycast.sv */
// Per edge item, multiply steps, two square roots of NW/2 steps and two divides of NW steps
// share one unit; parallel or degenerate lines skip the divides and the second root, and a
// point that falls outside either segment skips the second root.
// Throughput: one item at a time; a result waiting in the output register stalls a last item.
// Reset (synchronous, rst high) clears the latched ray, both bests and all control state.
// Depends on nshr_pkg, nshr_if, nshr_unit.
`default_nettype none
module nearest_segment_hit_raycast #(
  parameter int COORD_BITS = 16,
  parameter int TAG_BITS   = 8
) (
  input logic clk,
  input logic rst,
  nshr_in_if.sink    inp,
  nshr_out_if.source res
);
  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int DEN_W = 2 * DW + 1;
  localparam int L_W   = 2 * CB + 1;
  localparam int NUM_W = L_W + DW + 1;
  localparam int PW    = L_W + DW;
  localparam int NW    = NUM_W + (NUM_W % 2);
  localparam int QW    = NW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_LAUNCH = 3'd2, S_WAIT = 3'd3,
                         S_CHK = 3'd4, S_UPD = 3'd5, S_FIN = 3'd6;
  localparam logic [1:0] J_SQS = 2'd0, J_DIVX = 2'd1, J_DIVY = 2'd2, J_SQD = 2'd3;

  logic [2:0] state;
  logic [1:0] job;
  logic [3:0] step;

  logic signed [CB-1:0] sx, sy, tx, ty, ux, uy, vx, vy;
  logic last_r, robot_r;
  logic [TAG_BITS-1:0] tag_r;

  logic signed [NUM_W-1:0] acc;
  logic signed [DEN_W-1:0] den;
  logic signed [L_W-1:0]   l1, l2;
  logic signed [NUM_W-1:0] numx, numy, nstart, nd;
  logic signed [QW-1:0]    rx, ry;
  logic [CB:0]             sd;
  logic [NW-1:0]           dval;

  logic           ofound, rfound;
  logic [CB:0]    odist, rdist;
  logic [CB-1:0]  opx, opy, rpx, rpy;
  logic [TAG_BITS-1:0] otag, rtag;

  logic signed [DW-1:0] dsx, dsy, dux, duy, ax, ay;
  logic signed [L_W-1:0] ma;
  logic signed [DW-1:0]  mb;
  logic signed [PW-1:0]  prod;
  logic signed [NUM_W-1:0] sum;
  logic sub;

  nshr_pkg::unit_ctl_t uctl;
  logic [NW-1:0]    u_opnd;
  logic [DEN_W-1:0] u_div;
  logic u_busy, u_done, u_remnz;
  logic [NW-1:0] u_res;
  logic signed [QW-1:0] qv;
  logic qneg, within_all;

  function automatic logic [NUM_W-1:0] mag(input logic signed [NUM_W-1:0] v);
    mag = v[NUM_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic inr(input logic signed [QW-1:0] v,
                               input logic signed [CB-1:0] p, input logic signed [CB-1:0] q);
    logic signed [QW-1:0] lo, hi;
    lo = (p < q) ? QW'(p) : QW'(q);
    hi = (p < q) ? QW'(q) : QW'(p);
    inr = (lo <= v) && (v <= hi);
  endfunction

  assign dsx = DW'(sx) - DW'(tx);
  assign dsy = DW'(sy) - DW'(ty);
  assign dux = DW'(ux) - DW'(vx);
  assign duy = DW'(uy) - DW'(vy);
  assign ax  = DW'(sx) - DW'($signed(rx[CB-1:0]));
  assign ay  = DW'(sy) - DW'($signed(ry[CB-1:0]));

  always_comb begin
    ma = '0;
    mb = '0;
    sub = 1'b1;
    case (step)
      4'd0:  begin ma = L_W'(dsx); mb = duy; end
      4'd1:  begin ma = L_W'(dsy); mb = dux; end
      4'd2:  begin ma = L_W'(sx);  mb = DW'(ty); end
      4'd3:  begin ma = L_W'(sy);  mb = DW'(tx); end
      4'd4:  begin ma = L_W'(ux);  mb = DW'(vy); end
      4'd5:  begin ma = L_W'(uy);  mb = DW'(vx); end
      4'd6:  begin ma = l1;        mb = dux; end
      4'd7:  begin ma = l2;        mb = dsx; end
      4'd8:  begin ma = l1;        mb = duy; end
      4'd9:  begin ma = l2;        mb = dsy; end
      4'd10: begin ma = L_W'(dsx); mb = dsx; end
      4'd11: begin ma = L_W'(dsy); mb = dsy; sub = 1'b0; end
      4'd12: begin ma = L_W'(ax);  mb = ax; end
      4'd13: begin ma = L_W'(ay);  mb = ay; sub = 1'b0; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    sum  = sub ? acc - NUM_W'(prod) : acc + NUM_W'(prod);
  end

  always_comb begin
    uctl.start = state == S_LAUNCH;
    uctl.mode  = (job == J_SQS || job == J_SQD) ? nshr_pkg::MODE_SQRT : nshr_pkg::MODE_DIV;
    u_div      = $unsigned(den[DEN_W-1] ? -den : den);
    case (job)
      J_SQS:   u_opnd = NW'(mag(nstart));
      J_DIVX:  u_opnd = NW'(mag(numx));
      J_DIVY:  u_opnd = NW'(mag(numy));
      default: u_opnd = NW'(mag(nd));
    endcase
    qv   = $signed({1'b0, u_res});
    qneg = ((job == J_DIVX) ? numx[NUM_W-1] : numy[NUM_W-1]) ^ den[DEN_W-1];
    within_all = inr(rx, sx, tx) && inr(ry, sy, ty) && inr(rx, ux, vx) && inr(ry, uy, vy);
  end

  nshr_unit #(.NW(NW), .DVW(DEN_W)) u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .operand(u_opnd), .divisor(u_div),
    .busy(u_busy), .done(u_done), .result(u_res), .rem_nz(u_remnz)
  );

  assign inp.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      job    <= J_SQS;
      step   <= '0;
      sx <= '0; sy <= '0; tx <= '0; ty <= '0;
      ofound <= 1'b0; rfound <= 1'b0;
      odist <= '0; rdist <= '0;
      opx <= '0; opy <= '0; rpx <= '0; rpy <= '0;
      otag <= '0; rtag <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !(state == S_FIN && last_r)) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (inp.valid) begin
          if (inp.first) begin
            sx <= inp.ray_start_x; sy <= inp.ray_start_y;
            tx <= inp.ray_end_x;   ty <= inp.ray_end_y;
            ofound <= 1'b0; rfound <= 1'b0;
            odist <= '0; rdist <= '0;
            opx <= '0; opy <= '0; rpx <= '0; rpy <= '0;
            otag <= '0; rtag <= '0;
          end
          ux <= inp.edge_a_x; uy <= inp.edge_a_y;
          vx <= inp.edge_b_x; vy <= inp.edge_b_y;
          tag_r <= inp.part_tag; robot_r <= inp.is_robot; last_r <= inp.last;
          step <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (!step[0]) acc <= NUM_W'(prod);
          else begin
            case (step)
              4'd1:  den    <= DEN_W'(sum);
              4'd3:  l1     <= L_W'(sum);
              4'd5:  l2     <= L_W'(sum);
              4'd7:  numx   <= sum;
              4'd9:  numy   <= sum;
              4'd11: nstart <= sum;
              default: nd   <= sum;
            endcase
          end
          step <= step + 1'b1;
          if (step == 4'd11) begin
            job <= J_SQS;
            state <= S_LAUNCH;
          end else if (step == 4'd13) begin
            job <= J_SQD;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: state <= S_WAIT;
        S_WAIT: if (u_done) begin
          case (job)
            J_SQS: begin
              sd <= (CB+1)'(u_res + NW'(u_remnz) + NW'(1));
              if (den != '0) begin
                job <= J_DIVX;
                state <= S_LAUNCH;
              end else state <= S_FIN;
            end
            J_DIVX: begin
              rx <= qneg ? -qv : qv;
              job <= J_DIVY;
              state <= S_LAUNCH;
            end
            J_DIVY: begin
              ry <= qneg ? -qv : qv;
              state <= S_CHK;
            end
            default: begin
              dval <= u_res;
              state <= S_UPD;
            end
          endcase
        end
        S_CHK: begin
          step <= 4'd12;
          state <= within_all ? S_MUL : S_FIN;
        end
        S_UPD: begin
          if (dval < NW'(sd)) begin
            if (robot_r) begin
              if (!rfound || (CB+1)'(dval) < rdist) begin
                rfound <= 1'b1; rdist <= (CB+1)'(dval);
                rpx <= rx[CB-1:0]; rpy <= ry[CB-1:0]; rtag <= tag_r;
              end
            end else if (!ofound || (CB+1)'(dval) < odist) begin
              ofound <= 1'b1; odist <= (CB+1)'(dval);
              opx <= rx[CB-1:0]; opy <= ry[CB-1:0]; otag <= tag_r;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!last_r) state <= S_IDLE;
          else if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            if (rfound && (!ofound || rdist < odist)) begin
              res.hit <= 1'b1; res.distance <= rdist;
              res.hit_x <= rpx; res.hit_y <= rpy; res.hit_tag <= rtag;
            end else if (ofound) begin
              res.hit <= 1'b1; res.distance <= odist;
              res.hit_x <= opx; res.hit_y <= opy; res.hit_tag <= otag;
            end else begin
              res.hit <= 1'b0; res.distance <= sd;
              res.hit_x <= '0; res.hit_y <= '0; res.hit_tag <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (inp.valid && inp.ready) |=> state == S_MUL)
    else $error("item accepted but sequencer did not start");
  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> last_r)
    else $error("result produced for an item without last");
  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    inp.ready |-> !u_busy)
    else $error("ready while the shared unit is busy");
`endif
endmodule
`default_nettype wire
